[sv/mrrf_pkg.sv]
`default_nettype none

package mrrf_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_BAD_FUNC  = 3'd3,
        ST_SILENCE   = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_READ      = 3'd6
    } status_t;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FN_READ_HOLD   = 8'h03;
    localparam logic [7:0]  FN_WRITE_ONE   = 8'h06;
    localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
    localparam logic [8:0]  LEN_FIXED      = 9'd8;
    localparam logic [8:0]  LEN_OVERHEAD   = 9'd5;
    localparam logic [8:0]  LEN_NON_DATA   = 9'd4;
    localparam logic [15:0] SILENCE_RESET  = 16'd4;
    localparam logic [15:0] SILENCE_MAX    = 16'hFFFF;

    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] frame_address;
        logic [7:0] frame_function;
        logic [8:0] payload_len;
    } result_t;

    // one byte through the reflected crc, bit by bit
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/mrrf_payload_ram.sv]
`default_nettype none

module mrrf_payload_ram
    import mrrf_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data_reg
);

    logic [7:0] mem_array [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/mrrf_frame_ctrl.sv]
`default_nettype none

module mrrf_frame_ctrl
    import mrrf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256,
    parameter int AW           = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          take,
    input  wire logic [1:0]    kind,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [7:0]    read_index,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    output result_t            res,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    output logic               rd_in_range
);

    localparam logic [9:0] DEPTH_W = 10'(BUFFER_DEPTH);

    logic [15:0] silence_ticks_reg;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [8:0]  expected_len_reg, expected_len_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_pre_reg, crc_pre_next;
    logic [15:0] silence_count_reg, silence_count_next;
    logic        discarding_reg, discarding_next;
    logic [7:0]  hdr_addr_reg, hdr_addr_next;
    logic [7:0]  hdr_func_reg, hdr_func_next;
    logic [7:0]  third_byte_reg, third_byte_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic [8:0]    p;
    logic          p_in_range;
    logic [AW+8:0] p_ext;
    logic [AW+7:0] ri_ext;
    logic [8:0]    exp_new;
    logic [8:0]    exp_cur;
    logic [15:0]   crc_cur;
    logic [9:0]    idx_p1;
    logic [9:0]    idx_p2;
    logic [15:0]   silence_inc;
    logic          func_ok;

    assign p          = byte_count_reg - 9'd2;
    assign p_in_range = ({1'b0, p} < DEPTH_W);
    assign p_ext      = {{AW{1'b0}}, p};
    assign ri_ext     = {{AW{1'b0}}, read_index};
    assign idx_p1     = {1'b0, byte_count_reg} + 10'd1;
    assign idx_p2     = {1'b0, byte_count_reg} + 10'd2;
    assign func_ok    = (hdr_func_reg == FN_WRITE_ONE) || (hdr_func_reg == FN_WRITE_MULTI)
                        || (hdr_func_reg == FN_READ_HOLD);
    assign exp_new    = ((hdr_func_reg == FN_WRITE_ONE) || (hdr_func_reg == FN_WRITE_MULTI))
                        ? LEN_FIXED : ({1'b0, third_byte_reg} + LEN_OVERHEAD);
    assign exp_cur    = (byte_count_reg == 9'd4) ? exp_new : expected_len_reg;
    // byte three is a crc byte only for a five byte frame
    assign crc_cur    = (byte_count_reg != 9'd4) ? crc_reg
                        : ((exp_new > LEN_OVERHEAD) ? crc_reg : crc_pre_reg);
    assign silence_inc = (silence_count_reg == SILENCE_MAX) ? silence_count_reg
                         : silence_count_reg + 16'd1;

    assign wr_addr     = p_ext[AW-1:0];
    assign wr_data     = rx_byte;
    assign rd_addr     = ri_ext[AW-1:0];
    assign rd_in_range = ({2'b00, read_index} < DEPTH_W);
    assign rd_en       = take && (kind == KIND_READ);

    always_comb begin
        byte_count_next    = byte_count_reg;
        expected_len_next  = expected_len_reg;
        crc_next           = crc_reg;
        crc_pre_next       = crc_pre_reg;
        silence_count_next = silence_count_reg;
        discarding_next    = discarding_reg;
        hdr_addr_next      = hdr_addr_reg;
        hdr_func_next      = hdr_func_reg;
        third_byte_next    = third_byte_reg;
        crc_low_next       = crc_low_reg;
        wr_en              = 1'b0;
        res.valid          = 1'b0;
        res.status         = ST_OK;
        res.frame_address  = hdr_addr_reg;
        res.frame_function = hdr_func_reg;
        res.payload_len    = 9'd0;

        case (kind)
            KIND_BYTE: begin
                silence_count_next = 16'd0;
                if (!discarding_reg) begin
                    byte_count_next = byte_count_reg + 9'd1;
                    if (byte_count_reg == 9'd0) begin
                        hdr_addr_next = rx_byte;
                    end
                    if (byte_count_reg == 9'd1) begin
                        hdr_func_next = rx_byte;
                    end
                    if (byte_count_reg == 9'd2) begin
                        third_byte_next = rx_byte;
                    end
                    wr_en = take && (byte_count_reg >= 9'd2) && p_in_range;

                    if (byte_count_reg < 9'd3) begin
                        crc_next = crc16_feed(crc_reg, rx_byte);
                    end else if (byte_count_reg == 9'd3) begin
                        crc_low_next = rx_byte;
                        crc_pre_next = crc_reg;
                        crc_next     = crc16_feed(crc_reg, rx_byte);
                    end else if (byte_count_reg == 9'd4 && hdr_addr_reg == 8'h00) begin
                        res.valid         = 1'b1;
                        res.status        = ST_BAD_ADDR;
                        byte_count_next   = 9'd0;
                        expected_len_next = 9'd0;
                        crc_next          = CRC_INIT;
                        discarding_next   = 1'b1;
                    end else if (byte_count_reg == 9'd4 && !func_ok) begin
                        res.valid         = 1'b1;
                        res.status        = ST_BAD_FUNC;
                        byte_count_next   = 9'd0;
                        expected_len_next = 9'd0;
                        crc_next          = CRC_INIT;
                        discarding_next   = 1'b1;
                    end else begin
                        expected_len_next = exp_cur;
                        crc_next          = crc_cur;
                        if (idx_p2 < {1'b0, exp_cur}) begin
                            if (!p_in_range) begin
                                res.valid         = 1'b1;
                                res.status        = ST_OVERFLOW;
                                byte_count_next   = 9'd0;
                                expected_len_next = 9'd0;
                                crc_next          = CRC_INIT;
                                discarding_next   = 1'b1;
                            end else begin
                                crc_next = crc16_feed(crc_cur, rx_byte);
                            end
                        end else if (idx_p2 == {1'b0, exp_cur}) begin
                            crc_low_next = rx_byte;
                        end else if (idx_p1 == {1'b0, exp_cur}) begin
                            res.valid         = 1'b1;
                            res.status        = ({rx_byte, crc_low_reg} == crc_cur)
                                                ? ST_OK : ST_CRC_ERR;
                            res.payload_len   = exp_cur - LEN_NON_DATA;
                            byte_count_next   = 9'd0;
                            expected_len_next = 9'd0;
                            crc_next          = CRC_INIT;
                        end
                    end
                end
            end
            KIND_TICK: begin
                silence_count_next = silence_inc;
                if (silence_inc >= silence_ticks_reg) begin
                    silence_count_next = 16'd0;
                    discarding_next    = 1'b0;
                    byte_count_next    = 9'd0;
                    expected_len_next  = 9'd0;
                    crc_next           = CRC_INIT;
                    if (discarding_reg || byte_count_reg != 9'd0) begin
                        res.valid          = 1'b1;
                        res.status         = ST_SILENCE;
                        res.frame_address  = 8'h00;
                        res.frame_function = 8'h00;
                    end
                end
            end
            KIND_READ: begin
                res.valid          = 1'b1;
                res.status         = ST_READ;
                res.frame_address  = 8'h00;
                res.frame_function = 8'h00;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_ticks_reg <= SILENCE_RESET;
        end else if (cfg_we) begin
            silence_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg    <= 9'd0;
            expected_len_reg  <= 9'd0;
            crc_reg           <= CRC_INIT;
            crc_pre_reg       <= CRC_INIT;
            silence_count_reg <= 16'd0;
            discarding_reg    <= 1'b0;
            hdr_addr_reg      <= 8'h00;
            hdr_func_reg      <= 8'h00;
            third_byte_reg    <= 8'h00;
            crc_low_reg       <= 8'h00;
        end else if (take) begin
            byte_count_reg    <= byte_count_next;
            expected_len_reg  <= expected_len_next;
            crc_reg           <= crc_next;
            crc_pre_reg       <= crc_pre_next;
            silence_count_reg <= silence_count_next;
            discarding_reg    <= discarding_next;
            hdr_addr_reg      <= hdr_addr_next;
            hdr_func_reg      <= hdr_func_next;
            third_byte_reg    <= third_byte_next;
            crc_low_reg       <= crc_low_next;
        end
    end

endmodule

`default_nettype wire

[sv/modbus_rtu_response_framer.sv]
// output: a result beat is presented in the cycle after its input beat is accepted
// throughput: one input beat per cycle unless the output stalls; the crc byte
//   update and the frame checks sit between the frame state registers and the result
//   register, and buffer reads use the registered read port of the payload memory
// reset: aresetn is synchronous, active low; it clears the frame state, sets
//   the crc to 0xffff and the silence threshold to 4; the payload buffer is not cleared
`default_nettype none

module modbus_rtu_response_framer
    import mrrf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // rx_byte [7:0], read_index [15:8]
    input  wire logic [1:0]  s_tuser,   // kind [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // frame_address [7:0], frame_function [15:8],
                                        // payload_len [24:16], read_byte [32:25]
    output logic [2:0]       m_tuser,   // status [2:0]
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          take;
    result_t       res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg;
    status_t       out_status_reg;
    logic [7:0]    out_addr_reg;
    logic [7:0]    out_func_reg;
    logic [8:0]    out_plen_reg;
    logic          rd_keep_reg;
    logic [7:0]    read_byte;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    mrrf_frame_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .kind        (s_tuser),
        .rx_byte     (s_tdata[7:0]),
        .read_index  (s_tdata[15:8]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .res         (res),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_in_range (rd_in_range)
    );

    mrrf_payload_ram #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // ram read data is loaded on the same edge and held until the next accepted beat
    always_ff @(posedge aclk) begin
        if (take) begin
            out_status_reg <= res.status;
            out_addr_reg   <= res.frame_address;
            out_func_reg   <= res.frame_function;
            out_plen_reg   <= res.payload_len;
            rd_keep_reg    <= rd_en && rd_in_range;
        end
    end

    assign read_byte = rd_keep_reg ? rd_data_reg : 8'h00;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {7'b0000000, read_byte, out_plen_reg, out_func_reg, out_addr_reg};

    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_READ |=> m_tvalid && m_tuser == ST_READ)
        else $error("read beat did not produce a read result");

    a_byte_never_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_BYTE |=> !(m_tvalid && m_tuser == ST_READ))
        else $error("byte beat produced a read result");

    a_len_only_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24:16] != 9'd0 |-> m_tuser == ST_OK || m_tuser == ST_CRC_ERR)
        else $error("payload length on a non-frame result");

endmodule

`default_nettype wire
